// ===== rtl/core/qwsg_pkg.sv =====
// Shared constants for the quarter-wave sine generator.
package qwsg_pkg;

    localparam int ROM_W      = 15;
    localparam int STEP_W     = 12;
    localparam int AMP_W      = 15;
    localparam int OFFSET_W   = 15;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd1;

    localparam logic CMD_NEXT    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [AMP_W-1:0] AMP_RESET = 15'h7FFF;

    localparam logic [63:0] PIH_Q60      = 64'h1921FB54442D1846;
    localparam int          TAYLOR_TERMS = 11;

    // Denominators (2k)(2k+1) of successive Taylor terms of the sine.
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS-1] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

endpackage

// ===== rtl/core/qwsg_rom.sv =====
// Quarter-sine lookup ROM with registered read data.
module qwsg_rom
    import qwsg_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                          i_clk,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_addr,
    output logic [ROM_W-1:0]              o_data
);

    typedef logic [ROM_W-1:0] t_rom_array [TABLE_SIZE];

    localparam logic [63:0] THETA_UNIT = PIH_Q60 / (64'(2 * TABLE_SIZE));

    function automatic t_rom_array f_build_rom();
        t_rom_array         tbl;
        logic [63:0]        theta;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int j = 0; j < TABLE_SIZE; j++) begin
            theta = (THETA_UNIT * 64'(2 * j + 1)) >> 30;
            t2    = (theta * theta) >> 30;
            term  = theta;
            sum   = $signed(theta);
            for (int k = 1; k < TAYLOR_TERMS; k++) begin
                term = ((term * t2) >> 30) / TAYLOR_DIV[k-1];
                if (k[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = ($unsigned(sum) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tbl[j] = ROM_W'(v);
        end
        return tbl;
    endfunction

    localparam t_rom_array ROM_INIT = f_build_rom();

    logic [ROM_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM_INIT[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/quarter_wave_sine_generator_core.sv =====
// Top level of the quarter-wave sine generator: phase accumulator, ROM lookup and scaling.
// A sample word passes S_MUL, then S_EMIT, where its result is registered once the output
// is free; no new word is taken before that. A restart word reduces the offset (plus one
// if nonzero) times step modulo the cycle length by a reciprocal multiplication in S_QUO
// and S_RED, reads the ROM in S_LOOK and passes S_MUL and S_EMIT. The output register lets
// the next word in; synchronous reset clears phase and step and sets full-scale amplitude.
module quarter_wave_sine_generator_core
    import qwsg_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [OFFSET_W-1:0]   i_start_offset,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CYCLE_LEN = 4 * TABLE_SIZE;
    localparam int PHW       = $clog2(CYCLE_LEN);
    localparam int AW        = $clog2(TABLE_SIZE);
    localparam int PRODW     = OFFSET_W + 1 + PHW;
    localparam int RECIP_SH  = PRODW + PHW;
    localparam int RECIP_W   = PRODW + 1;
    localparam int QPW       = PRODW + RECIP_W;
    localparam int QUO_W     = QPW - RECIP_SH;
    localparam int STEP_SMAX = STEP_W - PHW;
    localparam int SW        = STEP_W + 1;

    // The rounded-up reciprocal gives the exact quotient for every product below 2**PRODW.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(CYCLE_LEN - 1)) / 64'(CYCLE_LEN));

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_QUO  = 6'b000010,
        S_RED  = 6'b000100,
        S_LOOK = 6'b001000,
        S_MUL  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    function automatic logic [PHW-1:0] f_step_mod(input logic [STEP_W-1:0] v);
        logic [SW-1:0] r;
        logic [SW-1:0] cand;
        r = {1'b0, v};
        for (int s = STEP_SMAX; s >= 0; s--) begin
            cand = SW'(CYCLE_LEN) << s;
            if (r >= cand) begin
                r = r - cand;
            end
        end
        return PHW'(r);
    endfunction

    t_state                  r_state, n_state;
    logic [PHW-1:0]          r_phase, n_phase;
    logic [PHW-1:0]          r_step_mod;
    logic [AMP_W-1:0]        r_amp;
    logic [PRODW-1:0]        r_red, n_red;
    logic [QUO_W-1:0]        r_quo;
    logic [ROM_W+AMP_W-1:0]  r_prod;
    logic                    r_neg;
    logic                    r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic                    in_acc;
    logic                    out_free;
    logic [OFFSET_W:0]       off_plus;
    logic [QPW-1:0]          quo_prod;
    logic [PRODW-1:0]        red_rem;
    logic [1:0]              quad;
    logic [PHW-1:0]          quad_base;
    logic [AW-1:0]           quad_pos;
    logic [AW-1:0]           rom_addr;
    logic [ROM_W-1:0]        rom_data;
    logic [PHW:0]            phase_sum;
    logic [PHW-1:0]          phase_next;
    logic [ROM_W-1:0]        mag_scaled;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_sample    = r_sample;

    assign off_plus = {1'b0, i_start_offset} + (OFFSET_W+1)'(i_start_offset != '0);
    assign quo_prod = QPW'(r_red) * QPW'(RECIP);
    assign red_rem  = r_red - PRODW'(r_quo) * PRODW'(CYCLE_LEN);

    always_comb begin
        if (r_phase >= PHW'(3 * TABLE_SIZE)) begin
            quad      = 2'd3;
            quad_base = PHW'(3 * TABLE_SIZE);
        end else if (r_phase >= PHW'(2 * TABLE_SIZE)) begin
            quad      = 2'd2;
            quad_base = PHW'(2 * TABLE_SIZE);
        end else if (r_phase >= PHW'(TABLE_SIZE)) begin
            quad      = 2'd1;
            quad_base = PHW'(TABLE_SIZE);
        end else begin
            quad      = 2'd0;
            quad_base = '0;
        end
        quad_pos = AW'(r_phase - quad_base);
        rom_addr = quad[0] ? (AW'(TABLE_SIZE - 1) - quad_pos) : quad_pos;
    end

    assign phase_sum  = {1'b0, r_phase} + {1'b0, r_step_mod};
    assign phase_next = (phase_sum >= (PHW+1)'(CYCLE_LEN))
                      ? PHW'(phase_sum - (PHW+1)'(CYCLE_LEN)) : PHW'(phase_sum);
    assign mag_scaled = r_prod[ROM_W+AMP_W-1:AMP_W];

    qwsg_rom #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_rom (
        .i_clk (i_clk),
        .i_addr(rom_addr),
        .o_data(rom_data)
    );

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_red   = r_red;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_RESTART) begin
                        n_red   = PRODW'(off_plus) * PRODW'(r_step_mod);
                        n_state = S_QUO;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_QUO: begin
                n_state = S_RED;
            end
            S_RED: begin
                n_phase = PHW'(red_rem);
                n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_phase = phase_next;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_step_mod  <= '0;
            r_amp       <= AMP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_PHASE_STEP: r_step_mod <= f_step_mod(i_cfg_data[STEP_W-1:0]);
                    CFG_AMPLITUDE:  r_amp      <= i_cfg_data[AMP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_red <= n_red;
        r_quo <= quo_prod[QPW-1:RECIP_SH];
        if (r_state == S_MUL) begin
            r_prod <= (ROM_W+AMP_W)'(rom_data) * (ROM_W+AMP_W)'(r_amp);
            r_neg  <= quad[1];
        end
        if (r_state == S_EMIT && out_free) begin
            r_sample <= r_neg ? -$signed({1'b0, mag_scaled}) : $signed({1'b0, mag_scaled});
        end
    end

endmodule

// ===== rtl/core/qwsg_checker.sv =====
// Port-level assertions for the quarter-wave sine generator, bound to the top level.
module qwsg_checker
    import qwsg_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [SAMPLE_W-1:0] o_sample
);

    logic in_acc;

    assign in_acc = i_valid && o_ready;

    // A waiting result word holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sample)))
        else $error("result word changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid directly after reset");

    // One word is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("input accepted again in the cycle after an acceptance");

    a_latency_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (!$past(in_acc, 1) && !$past(in_acc, 2)))
        else $error("result appeared sooner than the lookup allows");

endmodule

bind quarter_wave_sine_generator_core qwsg_checker u_qwsg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_sample(o_sample)
);
